// File: design/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg
// Shared types and constants for the matrix multiply-accumulate block.
// ----------------------------------------------------------------------------
package mma_pkg;

  localparam int ROW_W  = 3;   // row / column index width
  localparam int VAL_W  = 32;  // element width
  localparam int SIZE_W = 4;   // size register width

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  typedef enum logic [1:0] {
    ACT_LOAD_X  = 2'd0,
    ACT_LOAD_Y  = 2'd1,
    ACT_LOAD_Z  = 2'd2,
    ACT_COMPUTE = 2'd3
  } action_t;

  typedef struct packed {
    action_t            action;
    logic [ROW_W-1:0]   row;
    logic [ROW_W-1:0]   col;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]   out_row;
    logic [ROW_W-1:0]   out_col;
    logic signed [VAL_W-1:0] out_value;
    logic               last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic             take;   // input channel ready
    logic             issue;  // read X[i][k], Y[k][j] this cycle
    logic             zload;  // read Z[i][j] this cycle, seeds the accumulator
    logic             emit;   // write back Z[i][j] and load the output register
    logic             last;
    logic [ROW_W-1:0] i;
    logic [ROW_W-1:0] j;
    logic [ROW_W-1:0] k;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic busy;      // MAC pipeline still holds work
    logic out_free;  // output register can take a result this cycle
  } sts_t;

endpackage

// File: design/mma_stream_if.sv
// ----------------------------------------------------------------------------
// mma_stream_if
// Valid/ready channel carrying one payload of type T per transfer.
// ----------------------------------------------------------------------------
interface mma_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: design/mma_ram.sv
// ----------------------------------------------------------------------------
// mma_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/mma_datapath.sv
// ----------------------------------------------------------------------------
// mma_datapath
// Operand stores, multiply / accumulate pipeline and output register.
// ----------------------------------------------------------------------------
module mma_datapath #(
  parameter int MAX_N = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  mma_pkg::ctl_t     ctl,
  output mma_pkg::sts_t     sts,
  input  logic              in_accept,
  input  mma_pkg::in_item_t in_item,
  mma_stream_if.source      res
);

  localparam int DEPTH  = MAX_N * MAX_N;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ADDR_W-1:0] ld_addr, x_raddr, y_raddr, z_addr, z_waddr;
  logic              ld_ok, x_we, y_we, z_we;
  logic [mma_pkg::VAL_W-1:0] x_rd, y_rd, z_rd, z_wdata;
  logic [mma_pkg::VAL_W-1:0] prod, acc;
  logic              v1, v2, zload_d, zv_q;
  logic [DEPTH-1:0]  zvalid;

  assign ld_addr = ADDR_W'(int'(in_item.row) * MAX_N + int'(in_item.col));
  assign x_raddr = ADDR_W'(int'(ctl.i) * MAX_N + int'(ctl.k));
  assign y_raddr = ADDR_W'(int'(ctl.k) * MAX_N + int'(ctl.j));
  assign z_addr  = ADDR_W'(int'(ctl.i) * MAX_N + int'(ctl.j));

  // loads beyond the store are dropped
  assign ld_ok = in_accept && (int'(in_item.row) < MAX_N) && (int'(in_item.col) < MAX_N);
  assign x_we  = ld_ok && (in_item.action == mma_pkg::ACT_LOAD_X);
  assign y_we  = ld_ok && (in_item.action == mma_pkg::ACT_LOAD_Y);
  assign z_we  = (ld_ok && (in_item.action == mma_pkg::ACT_LOAD_Z)) || ctl.emit;

  assign z_waddr = ctl.emit ? z_addr : ld_addr;
  assign z_wdata = ctl.emit ? acc : in_item.value;

  mma_ram #(.WIDTH(mma_pkg::VAL_W), .DEPTH(DEPTH)) u_x_ram (
    .clk(clk), .we(x_we), .waddr(ld_addr), .wdata(in_item.value),
    .raddr(x_raddr), .rdata(x_rd)
  );

  mma_ram #(.WIDTH(mma_pkg::VAL_W), .DEPTH(DEPTH)) u_y_ram (
    .clk(clk), .we(y_we), .waddr(ld_addr), .wdata(in_item.value),
    .raddr(y_raddr), .rdata(y_rd)
  );

  mma_ram #(.WIDTH(mma_pkg::VAL_W), .DEPTH(DEPTH)) u_z_ram (
    .clk(clk), .we(z_we), .waddr(z_waddr), .wdata(z_wdata),
    .raddr(z_addr), .rdata(z_rd)
  );

  // Z entries read as zero until first written
  always_ff @(posedge clk) begin
    if (rst) begin
      zvalid <= '0;
    end else if (z_we) begin
      zvalid[z_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    zv_q <= zvalid[z_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      zload_d <= 1'b0;
    end else begin
      v1      <= ctl.issue;
      v2      <= v1;
      zload_d <= ctl.zload;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      prod <= mma_pkg::VAL_W'(x_rd * y_rd);
    end
    if (zload_d) begin
      acc <= zv_q ? z_rd : '0;
    end else if (v2) begin
      acc <= acc + prod;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (ctl.emit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      res.data.out_row   <= ctl.i;
      res.data.out_col   <= ctl.j;
      res.data.out_value <= acc;
      res.data.last      <= ctl.last;
    end
  end

  assign sts.busy     = v1 || v2 || zload_d;
  assign sts.out_free = !res.valid || res.ready;

endmodule

// File: design/mma_ctrl.sv
// ----------------------------------------------------------------------------
// mma_ctrl
// Sequencer: size register, element / k loop counters and state machine.
// ----------------------------------------------------------------------------
module mma_ctrl #(
  parameter int MAX_N = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  mma_pkg::action_t            in_action,
  input  logic                        cfg_write,
  input  logic [mma_pkg::SIZE_W-1:0]  cfg_data,
  input  mma_pkg::sts_t               sts,
  output mma_pkg::ctl_t               ctl
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ZREAD = 4'b0010,
    ST_MAC   = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  localparam logic [mma_pkg::SIZE_W-1:0] N_MAX = mma_pkg::SIZE_W'(MAX_N);

  state_t                        state;
  logic [mma_pkg::SIZE_W-1:0]    size, n;
  logic [mma_pkg::ROW_W-1:0]     i, j, k, nm1;
  logic                          k_end;

  // size 0 acts as 1, anything above MAX_N as MAX_N
  always_comb begin
    if (size == '0) begin
      n = mma_pkg::SIZE_W'(1);
    end else if (size > N_MAX) begin
      n = N_MAX;
    end else begin
      n = size;
    end
  end

  assign nm1   = mma_pkg::ROW_W'(n - mma_pkg::SIZE_W'(1));
  assign k_end = (k == nm1);

  assign ctl.take  = (state == ST_IDLE);
  assign ctl.issue = (state == ST_ZREAD) || (state == ST_MAC);
  assign ctl.zload = (state == ST_ZREAD);
  assign ctl.emit  = (state == ST_EMIT) && !sts.busy && sts.out_free;
  assign ctl.last  = (i == nm1) && (j == nm1);
  assign ctl.i     = i;
  assign ctl.j     = j;
  assign ctl.k     = k;

  always_ff @(posedge clk) begin
    if (rst) begin
      size <= mma_pkg::SIZE_RESET;
    end else if (cfg_write) begin
      size <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid && (in_action == mma_pkg::ACT_COMPUTE)) begin
            i     <= '0;
            j     <= '0;
            k     <= '0;
            state <= ST_ZREAD;
          end
        end
        ST_ZREAD, ST_MAC: begin
          if (k_end) begin
            state <= ST_EMIT;
          end else begin
            k     <= k + 1'b1;
            state <= ST_MAC;
          end
        end
        ST_EMIT: begin
          if (ctl.emit) begin
            k <= '0;
            if (j == nm1) begin
              j <= '0;
              if (i == nm1) begin
                state <= ST_IDLE;
              end else begin
                i     <= i + 1'b1;
                state <= ST_ZREAD;
              end
            end else begin
              j     <= j + 1'b1;
              state <= ST_ZREAD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/matrix_multiply_accumulate.sv
// Loads of X, Y or Z: one transfer per cycle while the sequencer is idle, no result.
// Compute: each Z[i][j] element takes n operand reads (the first one alongside
//   the Z read), a 2-stage multiply/add drain and a write back, one element at
//   a time through the single shared multiplier.
// Reset (rst, synchronous): size = 8, Z reads as zero, X and Y undefined.
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate
// Square integer matrix multiply-accumulate Z += X*Y with wrapping 32-bit math.
// Results leave through an output register, so loads continue while the last
// result waits.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate #(
  parameter int MAX_N = 8  // largest matrix dimension, 1..8
) (
  input logic          clk,
  input logic          rst,
  mma_stream_if.sink   cmd,  // mma_pkg::in_item_t per transfer
  mma_stream_if.sink   cfg,  // size, SIZE_W bits
  mma_stream_if.source res   // mma_pkg::out_item_t per transfer
);

  mma_pkg::ctl_t ctl;
  mma_pkg::sts_t sts;
  logic          in_accept;

  // The size register takes a write any cycle; the user must change it only while idle, the block does not enforce it.
  assign cfg.ready = 1'b1;

  // Input is taken only while the sequencer is idle; a compute transfer
  // holds off further input until its last result is in the output register.
  assign cmd.ready = ctl.take;
  assign in_accept = cmd.valid && ctl.take;

  mma_ctrl #(.MAX_N(MAX_N)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_action (cmd.data.action),
    .cfg_write (cfg.valid),
    .cfg_data  (mma_pkg::SIZE_W'(cfg.data)),
    .sts       (sts),
    .ctl       (ctl)
  );

  // Operand stores, the MAC pipeline (RAM read, multiply, add) and the
  // result register all sit in the datapath.
  mma_datapath #(.MAX_N(MAX_N)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .in_accept (in_accept),
    .in_item   (cmd.data),
    .res       (res)
  );

endmodule
